// File: design/skt_pkg.sv
// shared types and codes for the sorted key table
// no dependencies

package skt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int KEY_W         = 16;
    localparam int COUNT_W       = 7;
    localparam int SUM_W         = 14;

    // opcodes
    localparam logic [1:0] OPC_INSERT = 2'd0;
    localparam logic [1:0] OPC_DELETE = 2'd1;
    localparam logic [1:0] OPC_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] entry_class;
        logic [7:0] entry_value;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic [SUM_W-1:0]   value_sum;
    } t_out_req;

    // broadcast command to every cell
    typedef struct packed {
        logic do_insert;
        logic do_delete;
        logic do_clear;
        t_key key;
    } t_cell_cmd;

    // what one cell shows its neighbors
    typedef struct packed {
        logic valid;
        t_key entry;
    } t_link;

endpackage

// File: design/sorted_key_table_core.sv
// top level of the sorted key table: a chain of compare-and-shift cells
// depends on skt_pkg and skt_cell

// Sorted key table. Holds up to TABLE_DEPTH entries of {class, value},
// kept in ascending order in a row of cells. Every request is insert,
// delete or clear and produces exactly one response with a status, the
// entry count and the sum of held values. Each cell compares the broadcast
// key against its own entry and either keeps it, takes the key, or takes
// its left or right neighbor's entry; all cells update at the edge that
// takes the request. A request is taken every cycle, limited only by the
// response register (a new request is taken while the held response is
// drained); the response shows in the next cycle. Delete finds
// a match through the per-cell hit lines; duplicates are kept and a delete
// removes only one of them. Insert into a full table and delete of a
// missing entry leave the table alone and report it in the status. The
// entry count is reported on 7 bits and the value sum wraps on 14 bits.

module sorted_key_table_core #(
    parameter int TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  skt_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output skt_pkg::t_out_req o_out_data
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // chain wiring; index 0 is the left end (smallest entry)
    t_link                  links [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] at_after;
    logic [TABLE_DEPTH-1:0] hits;

    t_cell_cmd  cmd;
    logic       accept;
    logic       full;
    logic       found;
    t_key       key;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [1:0]       status;

    logic     r_out_valid;
    t_out_req r_out;

    // response register frees as the downstream takes it
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign key        = {i_in_data.entry_class, i_in_data.entry_value};

    // table is full when the rightmost cell holds an entry
    assign full  = links[TABLE_DEPTH-1].valid;
    // wired-or of the match lines
    assign found = |hits;

    assign cmd.key       = key;
    assign cmd.do_insert = accept && (i_in_data.opcode == OPC_INSERT) && !full;
    assign cmd.do_delete = accept && (i_in_data.opcode == OPC_DELETE) && found;
    assign cmd.do_clear  = accept && (i_in_data.opcode == OPC_CLEAR);

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_link left_link;
        t_link right_link;
        logic  left_at_after;

        if (g == 0) begin : g_left_end
            // the left end always accepts an insert and never shifts right
            assign left_link     = '{valid: 1'b1, entry: '0};
            assign left_at_after = 1'b0;
        end else begin : g_left_mid
            assign left_link     = links[g-1];
            assign left_at_after = at_after[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_right_end
            // shifting left out of the last cell leaves it empty
            assign right_link = '{valid: 1'b0, entry: '0};
        end else begin : g_right_mid
            assign right_link = links[g+1];
        end

        skt_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (cmd),
            .i_left          (left_link),
            .i_left_at_after (left_at_after),
            .i_right         (right_link),
            .o_link          (links[g]),
            .o_at_after      (at_after[g]),
            .o_hit           (hits[g])
        );
    end

    // count, sum and status for the request being taken
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        status  = ST_DONE;
        case (i_in_data.opcode)
            OPC_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_sum   = r_sum + SUM_W'(i_in_data.entry_value);
                end
            end
            OPC_DELETE: begin
                if (!found) begin
                    status = ST_MISSING;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_sum   = r_sum - SUM_W'(i_in_data.entry_value);
                end
            end
            OPC_CLEAR: begin
                n_count = '0;
                n_sum   = '0;
            end
            default: begin
                // unused opcode leaves everything as is
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_sum       <= n_sum;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.status      <= status;
            r_out.entry_count <= COUNT_W'(n_count);
            r_out.value_sum   <= n_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/skt_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbors
// depends on skt_pkg

module skt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skt_pkg::t_cell_cmd i_cmd,
    input  skt_pkg::t_link    i_left,
    input  logic              i_left_at_after,
    input  skt_pkg::t_link    i_right,
    output skt_pkg::t_link    o_link,
    output logic              o_at_after,
    output logic              o_hit
);
    import skt_pkg::*;

    logic r_valid;
    t_key r_entry;
    logic n_valid;
    t_key n_entry;
    logic key_le;

    assign key_le     = (r_entry >= i_cmd.key);
    // empty slot or entry not below the key: insert point is here or earlier
    assign o_at_after = !r_valid || key_le;
    assign o_hit      = r_valid && (r_entry == i_cmd.key);
    assign o_link     = '{valid: r_valid, entry: r_entry};

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_cmd.do_clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.do_insert) begin
            n_valid = r_valid || i_left.valid;
            if (i_left_at_after) begin
                n_entry = i_left.entry;
            end else if (o_at_after) begin
                n_entry = i_cmd.key;
            end
        end else if (i_cmd.do_delete) begin
            // removal point is the first held entry not below the key
            if (r_valid && key_le) begin
                n_valid = i_right.valid;
                n_entry = i_right.entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: test/tb_sorted_key_table_core.sv
// testbench for sorted_key_table_core: directed table, then phased random requests
// checked against an in-bench model of the sorted table; depends on skt_pkg
`timescale 1ns / 100ps

module tb_sorted_key_table_core;
    import skt_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int N_RANDOM = 1250;

    // opcode with no operation behind it
    localparam logic [1:0] OPC_UNUSED = 2'd3;

    // random phase shapes
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    // receiver stall patterns
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_TOGGLE = 1;
    localparam int RDY_RANDOM = 2;
    localparam int RDY_STALLS = 3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_req out_rsp;

    sorted_key_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_rsp)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("[sorted_key_table_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // model of the table: ascending 16-bit words {class, value}
    // ------------------------------------------------------------------
    logic [15:0]      tbl_keys [DEPTH];
    int               tbl_count = 0;
    logic [SUM_W-1:0] tbl_sum = '0;

    // responses still owed by the block, oldest first
    t_out_req pending_rsp [$];
    int       err_count = 0;

    function automatic t_out_req apply_table_op(input t_in_req r);
        t_out_req    rsp;
        logic [15:0] key;
        int          pos;
        key = {r.entry_class, r.entry_value};
        rsp.status = ST_DONE;
        pos = 0;
        case (r.opcode)
            OPC_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // equal keys stop the scan, so a new one lands ahead of its twins
                    while (pos < tbl_count && key > tbl_keys[pos]) pos++;
                    for (int i = tbl_count; i > pos; i--) tbl_keys[i] = tbl_keys[i-1];
                    tbl_keys[pos] = key;
                    tbl_count++;
                    tbl_sum = tbl_sum + SUM_W'(r.entry_value);
                end
            end
            OPC_DELETE: begin
                while (pos < tbl_count && tbl_keys[pos] != key) pos++;
                if (pos >= tbl_count) begin
                    rsp.status = ST_MISSING;
                end else begin
                    // only the first match goes
                    for (int i = pos; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
                    tbl_count--;
                    tbl_sum = tbl_sum - SUM_W'(r.entry_value);
                end
            end
            OPC_CLEAR: begin
                tbl_count = 0;
                tbl_sum = '0;
            end
            default: begin
            end
        endcase
        rsp.entry_count = COUNT_W'(tbl_count);
        rsp.value_sum = tbl_sum;
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // response side: stall pattern and checker
    // ------------------------------------------------------------------
    int rdy_mode = RDY_ALWAYS;
    int rdy_left = 0;
    int stall_left = 0;

    always @(posedge clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(RDY_ALWAYS, RDY_STALLS);
            rdy_left <= $urandom_range(10, 200);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS: out_ready <= 1'b1;
            RDY_TOGGLE: out_ready <= ~out_ready;
            RDY_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
            default: begin
                // mostly ready with the odd long stall
                if (stall_left > 0) begin
                    out_ready <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 20);
                end
            end
        endcase
    end

    always @(posedge clk) begin
        t_out_req want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response, status", out_rsp.status, -1);
            end else begin
                want = pending_rsp.pop_front();
                if (out_rsp.status !== want.status)
                    report_mismatch("status", out_rsp.status, want.status);
                if (out_rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", out_rsp.entry_count, want.entry_count);
                if (out_rsp.value_sum !== want.value_sum)
                    report_mismatch("value_sum", out_rsp.value_sum, want.value_sum);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    int burst_left = 0;

    // holds the request until taken, then books the response; a burst ends
    // with valid low before the next request
    task automatic push_req(input t_in_req r, input logic use_fixed, input t_out_req fixed_rsp);
        t_out_req model_rsp;
        in_req <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        model_rsp = apply_table_op(r);
        pending_rsp.push_back(use_fixed ? fixed_rsp : model_rsp);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [7:0] pick_class();
        case ($urandom_range(0, 3))
            0: return 8'h41 + 8'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_value();
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // most deletes aim at a held entry so the table actually shrinks
    function automatic t_in_req make_req(input int phase);
        t_in_req r;
        int      roll;
        int      ins_pct;
        roll = $urandom_range(0, 99);
        r.entry_class = pick_class();
        r.entry_value = pick_value();
        ins_pct = (phase == PH_FILL) ? 90 : (phase == PH_DRAIN) ? 15 : 50;
        if (roll < 3) begin
            r.opcode = OPC_UNUSED;
        end else if (roll < 5 && phase == PH_MIXED) begin
            r.opcode = OPC_CLEAR;
        end else if ($urandom_range(0, 99) < ins_pct) begin
            r.opcode = OPC_INSERT;
        end else begin
            r.opcode = OPC_DELETE;
            if (tbl_count > 0 && $urandom_range(0, 99) < 80)
                {r.entry_class, r.entry_value} = tbl_keys[$urandom_range(0, tbl_count - 1)];
        end
        return r;
    endfunction

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         cls;
        logic [7:0]         val;
        logic               fixed;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } t_dir_row;

    localparam int N_DIR = 22;

    // rows with fixed set carry their response; the others go to the model
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{OPC_DELETE, 8'h41, 8'h05, 1'b1, ST_MISSING, 7'd0, 14'd0},   // delete on empty table
        '{OPC_CLEAR,  8'h00, 8'h00, 1'b1, ST_DONE,    7'd0, 14'd0},
        '{OPC_UNUSED, 8'hff, 8'hff, 1'b1, ST_DONE,    7'd0, 14'd0},   // unused opcode
        '{OPC_INSERT, 8'hff, 8'hff, 1'b1, ST_DONE,    7'd1, 14'd255},
        '{OPC_INSERT, 8'h00, 8'h00, 1'b1, ST_DONE,    7'd2, 14'd255},
        '{OPC_INSERT, 8'h00, 8'h00, 1'b1, ST_DONE,    7'd3, 14'd255}, // duplicate
        '{OPC_INSERT, 8'h00, 8'hff, 1'b1, ST_DONE,    7'd4, 14'd510},
        '{OPC_INSERT, 8'hff, 8'h00, 1'b1, ST_DONE,    7'd5, 14'd510},
        '{OPC_INSERT, 8'h41, 8'h07, 1'b0, ST_DONE,    7'd0, 14'd0},
        '{OPC_INSERT, 8'h41, 8'h07, 1'b0, ST_DONE,    7'd0, 14'd0},
        '{OPC_INSERT, 8'h41, 8'h03, 1'b0, ST_DONE,    7'd0, 14'd0},
        '{OPC_DELETE, 8'h41, 8'h07, 1'b0, ST_DONE,    7'd0, 14'd0},   // one of two matches
        '{OPC_DELETE, 8'h41, 8'h07, 1'b0, ST_DONE,    7'd0, 14'd0},
        '{OPC_DELETE, 8'h41, 8'h07, 1'b0, ST_DONE,    7'd0, 14'd0},   // now missing
        '{OPC_DELETE, 8'h00, 8'h00, 1'b0, ST_DONE,    7'd0, 14'd0},   // head entry
        '{OPC_UNUSED, 8'h55, 8'haa, 1'b0, ST_DONE,    7'd0, 14'd0},
        '{OPC_DELETE, 8'hff, 8'hff, 1'b0, ST_DONE,    7'd0, 14'd0},   // tail entry
        '{OPC_DELETE, 8'h07, 8'h41, 1'b0, ST_DONE,    7'd0, 14'd0},   // swapped fields
        '{OPC_CLEAR,  8'haa, 8'h55, 1'b1, ST_DONE,    7'd0, 14'd0},
        '{OPC_INSERT, 8'h80, 8'h80, 1'b1, ST_DONE,    7'd1, 14'd128},
        '{OPC_DELETE, 8'h80, 8'h80, 1'b1, ST_DONE,    7'd0, 14'd0},
        '{OPC_DELETE, 8'h80, 8'h80, 1'b1, ST_MISSING, 7'd0, 14'd0}
    };

    initial begin
        t_in_req  r;
        t_out_req fixed_rsp;
        int       sent;
        int       phase;
        int       phase_len;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int n = 0; n < N_DIR; n++) begin
            r.opcode = DIR_ROWS[n].opcode;
            r.entry_class = DIR_ROWS[n].cls;
            r.entry_value = DIR_ROWS[n].val;
            fixed_rsp.status = DIR_ROWS[n].status;
            fixed_rsp.entry_count = DIR_ROWS[n].count;
            fixed_rsp.value_sum = DIR_ROWS[n].sum;
            push_req(r, DIR_ROWS[n].fixed, fixed_rsp);
        end

        // random phases; the first one fills the table past full
        phase = PH_FILL;
        phase_len = 110;
        while (sent < N_RANDOM) begin
            for (int k = 0; k < phase_len && sent < N_RANDOM; k++) begin
                r = make_req(phase);
                push_req(r, 1'b0, '0);
                if (r.opcode != OPC_UNUSED) sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                r.opcode = OPC_CLEAR;
                r.entry_class = pick_class();
                r.entry_value = pick_value();
                push_req(r, 1'b0, '0);
            end
            phase = $urandom_range(PH_FILL, PH_MIXED);
            phase_len = $urandom_range(20, 120);
        end
        in_valid <= 1'b0;

        // drain, then wait out anything stray
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0) begin
            $display("[sorted_key_table_core] OK");
        end else begin
            $display("[sorted_key_table_core] ERROR");
        end
        $finish;
    end

endmodule
